### hdl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg: shared types and constants of the bounded priority queue
// Sizes, entry and beat layouts, status codes and the controller to
// datapath command and status groups.
// ----------------------------------------------------------------------------
package bpq_pkg;

	// Sizes
	localparam int CAPACITY  = 16;
	localparam int PRIO_BITS = 8;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// Command codes of an input beat
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// Status codes of a result beat
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Input beat
	typedef struct packed {
		logic               command;
		logic [7:0]         item_priority;
		logic signed [31:0] item_value;
	} item_t;

	// Result beat
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_value;
		logic [7:0]         out_priority;
		logic [4:0]         fill_count;
	} result_t;

	// One stored entry
	typedef struct packed {
		logic [PRIO_BITS-1:0] prio;
		logic [31:0]          value;
	} entry_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic insert;      // store item at the tail, report done
		logic full;        // report full
		logic empty;       // report empty
		logic scan_start;  // read slot 0
		logic scan_step;   // compare read slot, read the next one
		logic shift_start; // read slot after the best one
		logic shift_step;  // move read slot down by one, read the next one
		logic finish;      // drop one entry, report the removed one
	} dp_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic is_full;
		logic is_empty;
		logic scan_last;
		logic best_is_last;
		logic shift_last;
	} dp_stat_t;

endpackage

### hdl/bpq_ctrl.sv
// ----------------------------------------------------------------------------
// bpq_ctrl: command sequencer of the bounded priority queue
// Accepts a beat, then steps the datapath through the priority scan and the
// shift that closes the gap left by the removed entry.
// ----------------------------------------------------------------------------
module bpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	input  bpq_pkg::dp_stat_t stat,
	output bpq_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_LOCATE = 4'b0100,
		S_SHIFT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (command == bpq_pkg::CMD_INSERT) begin
						if (stat.is_full) cmd.full = 1'b1;
						else              cmd.insert = 1'b1;
					end else if (stat.is_empty) begin
						cmd.empty = 1'b1;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_LOCATE;
			end
			S_LOCATE: begin
				if (stat.best_is_last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.shift_start = 1'b1;
					state_d         = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

### hdl/bpq_datapath.sv
// ----------------------------------------------------------------------------
// bpq_datapath: entry store, scan and shift registers of the queue
// Entries sit packed in insertion order; one read and one write port.
// Holds the entry count and the result register.
// ----------------------------------------------------------------------------
module bpq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  bpq_pkg::item_t    item,
	input  bpq_pkg::dp_cmd_t  cmd,
	output bpq_pkg::dp_stat_t stat,
	output bpq_pkg::result_t  result,
	output logic              done
);

	localparam int IW = bpq_pkg::IDX_W;
	localparam int CW = bpq_pkg::CNT_W;

	// Entry store
	bpq_pkg::entry_t mem [bpq_pkg::CAPACITY];
	bpq_pkg::entry_t rdata_q;
	bpq_pkg::entry_t wdata;
	logic [IW-1:0]   raddr, waddr;
	logic            we;

	// Count, scan and shift registers
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   pend_idx_q;  // slot whose data is in rdata_q during scan
	logic [IW-1:0]   best_idx_q;
	bpq_pkg::entry_t best_q;
	logic [IW-1:0]   wr_idx_q;
	logic [IW-1:0]   last_idx;
	logic            take;

	bpq_pkg::result_t res_q;
	logic             done_q;

	assign last_idx = IW'(count_q - CW'(1));

	// Status to the controller
	assign stat.is_full      = (count_q >= CW'(bpq_pkg::CAPACITY));
	assign stat.is_empty     = (count_q == '0);
	assign stat.scan_last    = (pend_idx_q == last_idx);
	assign stat.best_is_last = (best_idx_q == last_idx);
	assign stat.shift_last   = (IW'({1'b0, wr_idx_q} + (IW+1)'(1)) == last_idx);

	// New best: first slot, or strictly higher priority
	assign take = (pend_idx_q == '0) || (rdata_q.prio > best_q.prio);

	// Read address select
	always_comb begin
		raddr = '0;
		if (cmd.scan_step)   raddr = IW'({1'b0, pend_idx_q} + (IW+1)'(1));
		if (cmd.shift_start) raddr = IW'({1'b0, best_idx_q} + (IW+1)'(1));
		if (cmd.shift_step)  raddr = IW'({1'b0, wr_idx_q} + (IW+1)'(2));
	end

	// Write port select
	always_comb begin
		we    = cmd.insert | cmd.shift_step;
		waddr = wr_idx_q;
		wdata = rdata_q;
		if (cmd.insert) begin
			waddr      = IW'(count_q);
			wdata.prio = bpq_pkg::PRIO_BITS'(item.item_priority);
			wdata.value = item.item_value;
		end
	end

	// Memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Scan and shift bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.scan_start) pend_idx_q <= '0;
		if (cmd.scan_step) begin
			pend_idx_q <= IW'({1'b0, pend_idx_q} + (IW+1)'(1));
			if (take) begin
				best_idx_q <= pend_idx_q;
				best_q     <= rdata_q;
			end
		end
		if (cmd.shift_start) wr_idx_q <= best_idx_q;
		if (cmd.shift_step)  wr_idx_q <= IW'({1'b0, wr_idx_q} + (IW+1)'(1));
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (cmd.insert) count_q <= count_q + CW'(1);
			if (cmd.finish) count_q <= count_q - CW'(1);
		end
	end

	// Result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= cmd.insert | cmd.full | cmd.empty | cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.insert | cmd.full | cmd.empty | cmd.finish) begin
			res_q.status       <= bpq_pkg::ST_DONE;
			res_q.out_value    <= '0;
			res_q.out_priority <= '0;
			res_q.fill_count   <= 5'(count_q);
			if (cmd.full)   res_q.status <= bpq_pkg::ST_FULL;
			if (cmd.empty)  res_q.status <= bpq_pkg::ST_EMPTY;
			if (cmd.insert) res_q.fill_count <= 5'(count_q + CW'(1));
			if (cmd.finish) begin
				res_q.out_value    <= best_q.value;
				res_q.out_priority <= 8'(best_q.prio);
				res_q.fill_count   <= 5'(count_q - CW'(1));
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

### hdl/bounded_priority_queue.sv
// ----------------------------------------------------------------------------
// bounded_priority_queue: priority queue with highest-priority extraction
// Insert stores a data word with its priority; delete returns the entry of
// highest priority, the earliest one among equals.
//
//   channel  handshake       payload    direction
//   item     start / busy    item_t     in
//   result   done (strobe)   result_t   out
//
// Insert, full and empty beats are handled in the cycle they are taken; the
// result strobe comes on the next cycle. A delete runs a scan over the
// single read port of the entry store, then a shift of the later entries
// down by one slot.
// busy is high from the cycle after a delete is taken until it finishes.
// arst_n clears the count, the done strobe and the controller; the store needs no clearing.
// done is high for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module bounded_priority_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bpq_pkg::item_t   item,
	output logic             done,
	output bpq_pkg::result_t result
);

	bpq_pkg::dp_cmd_t  cmd;
	bpq_pkg::dp_stat_t stat;

	// Sequencer
	bpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (item.command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// Store and result
	bpq_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

endmodule
